[design/rv32i_instruction_executor_assert.svh]
// Assertion macros for the RV32I executor.
// Used by the top level; depends on nothing else.
`ifndef RV32I_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define RV32I_INSTRUCTION_EXECUTOR_ASSERT_SVH

// same-cycle implication
`define RV32IE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RV32IE_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// invariant
`define RV32IE_ASSERT_ALW(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

`endif

[design/rv32ie_pkg.sv]
// Shared types and constants of the RV32I executor.
// No dependencies.
package rv32ie_pkg;

    localparam int XLEN       = 32;
    localparam int REG_IDX_W  = 5;
    localparam int NUM_REGS   = 32;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 136;
    localparam int OUT_TUSER_W = 4;

    // opcodes
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
    localparam logic [31:0] UPPER_MASK  = 32'hFFFF_F000;
    localparam logic [31:0] WORD_ALIGN  = 32'hFFFF_FFFC;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // ALU funct3
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // branch funct3
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // jump funct3
    localparam logic [2:0] F3_JALR = 3'd0;

    // load / store funct3
    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;
    localparam logic [2:0] F3_SB  = 3'd0;
    localparam logic [2:0] F3_SH  = 3'd1;
    localparam logic [2:0] F3_SW  = 3'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [XLEN-1:0]      data;
    } t_rf_wr;

    typedef struct packed {
        logic [XLEN-1:0]      next_pc;
        logic [REG_IDX_W-1:0] dest_reg;
        logic [XLEN-1:0]      dest_value;
        logic                 mem_read;
        logic                 mem_write;
        logic [XLEN-1:0]      mem_addr;
        logic [XLEN-1:0]      store_data;
        logic [1:0]           access_size;
        logic                 halt;
        logic                 illegal;
    } t_exec_res;

endpackage

[design/rv32ie_regfile.sv]
// Integer register file: 32 x 32, one write port, two registered read ports.
// Depends on rv32ie_pkg. Entries read as zero until first written.
module rv32ie_regfile (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rv32ie_pkg::t_rf_wr               i_wr,
    input  logic                             i_rd_en,
    input  logic [rv32ie_pkg::REG_IDX_W-1:0] i_ra_addr,
    input  logic [rv32ie_pkg::REG_IDX_W-1:0] i_rb_addr,
    output logic [rv32ie_pkg::XLEN-1:0]      o_ra_data,
    output logic [rv32ie_pkg::XLEN-1:0]      o_rb_data
);

    logic [rv32ie_pkg::XLEN-1:0]     r_mem [rv32ie_pkg::NUM_REGS];
    logic [rv32ie_pkg::NUM_REGS-1:0] r_valid;
    logic [rv32ie_pkg::XLEN-1:0]     r_ra_mem;
    logic [rv32ie_pkg::XLEN-1:0]     r_rb_mem;
    logic [rv32ie_pkg::XLEN-1:0]     r_fwd_data;
    logic                            r_ra_fwd;
    logic                            r_rb_fwd;
    logic                            r_ra_zero;
    logic                            r_rb_zero;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_ra_mem   <= r_mem[i_ra_addr];
            r_rb_mem   <= r_mem[i_rb_addr];
            r_fwd_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_ra_fwd  <= 1'b0;
            r_rb_fwd  <= 1'b0;
            r_ra_zero <= 1'b1;
            r_rb_zero <= 1'b1;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                // write in the same cycle wins over the stale array word
                r_ra_fwd  <= i_wr.en && (i_wr.addr == i_ra_addr);
                r_rb_fwd  <= i_wr.en && (i_wr.addr == i_rb_addr);
                r_ra_zero <= !r_valid[i_ra_addr];
                r_rb_zero <= !r_valid[i_rb_addr];
            end
        end
    end

    assign o_ra_data = r_ra_fwd ? r_fwd_data : (r_ra_zero ? '0 : r_ra_mem);
    assign o_rb_data = r_rb_fwd ? r_fwd_data : (r_rb_zero ? '0 : r_rb_mem);

endmodule

[design/rv32ie_exec.sv]
// Decode and execute of one RV32I instruction, purely combinational.
// Depends on rv32ie_pkg.
module rv32ie_exec (
    input  logic [rv32ie_pkg::XLEN-1:0] i_instr,
    input  logic [rv32ie_pkg::XLEN-1:0] i_load_data,
    input  logic [rv32ie_pkg::XLEN-1:0] i_pc,
    input  logic [rv32ie_pkg::XLEN-1:0] i_rs1_data,
    input  logic [rv32ie_pkg::XLEN-1:0] i_rs2_data,
    output rv32ie_pkg::t_exec_res       o_res
);

    logic [6:0]  opcode;
    logic [2:0]  funct3;
    logic [6:0]  funct7;
    logic [4:0]  rd;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    logic [31:0] pc_plus4;
    logic [31:0] pc_imm;
    logic [31:0] pc_off;
    logic [31:0] ea;
    logic [31:0] ea_off;
    logic [31:0] alu_b;
    logic        alu_alt;
    logic [31:0] alu_out;
    logic [32:0] sub_ext;
    logic        lt_s;
    logic        lt_u;
    logic        eq;
    logic [7:0]  ld_byte;
    logic [15:0] ld_half;
    logic        wr;
    logic [31:0] val;
    logic        taken;
    logic        br_valid;

    assign opcode = i_instr[6:0];
    assign funct3 = i_instr[14:12];
    assign funct7 = i_instr[31:25];
    assign rd     = i_instr[11:7];

    assign imm_i = {{20{i_instr[31]}}, i_instr[31:20]};
    assign imm_s = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign imm_b = {{19{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                    i_instr[11:8], 1'b0};
    assign imm_j = {{11{i_instr[31]}}, i_instr[31], i_instr[19:12], i_instr[20],
                    i_instr[30:21], 1'b0};
    assign imm_u = i_instr & rv32ie_pkg::UPPER_MASK;

    // shared pc-relative adder: JAL, branches, AUIPC
    always_comb begin
        case (opcode)
            rv32ie_pkg::OPC_JAL:    pc_off = imm_j;
            rv32ie_pkg::OPC_BRANCH: pc_off = imm_b;
            default:                pc_off = imm_u;
        endcase
    end
    assign pc_plus4 = i_pc + 32'd4;
    assign pc_imm   = i_pc + pc_off;

    // shared rs1-relative adder: loads, stores, JALR
    assign ea_off = (opcode == rv32ie_pkg::OPC_STORE) ? imm_s : imm_i;
    assign ea     = i_rs1_data + ea_off;

    // compare unit
    assign sub_ext = {1'b0, i_rs1_data} - {1'b0, alu_b};
    assign lt_u    = sub_ext[32];
    assign lt_s    = (i_rs1_data[31] != alu_b[31]) ? i_rs1_data[31] : lt_u;
    assign eq      = (i_rs1_data == alu_b);

    // ALU operand and alternate select
    always_comb begin
        if (opcode == rv32ie_pkg::OPC_OP_IMM) begin
            alu_b   = imm_i;
            alu_alt = (funct3 == rv32ie_pkg::F3_SR) && (funct7 == rv32ie_pkg::F7_ALT);
        end else begin
            alu_b   = i_rs2_data;
            alu_alt = (opcode == rv32ie_pkg::OPC_OP) && (funct7 == rv32ie_pkg::F7_ALT);
        end
    end

    always_comb begin
        case (funct3)
            rv32ie_pkg::F3_ADD:  alu_out = alu_alt ? sub_ext[31:0] : i_rs1_data + alu_b;
            rv32ie_pkg::F3_SLL:  alu_out = i_rs1_data << alu_b[4:0];
            rv32ie_pkg::F3_SLT:  alu_out = {31'd0, lt_s};
            rv32ie_pkg::F3_SLTU: alu_out = {31'd0, lt_u};
            rv32ie_pkg::F3_XOR:  alu_out = i_rs1_data ^ alu_b;
            rv32ie_pkg::F3_SR:   alu_out = alu_alt ? 32'($signed(i_rs1_data) >>> alu_b[4:0])
                                                   : i_rs1_data >> alu_b[4:0];
            rv32ie_pkg::F3_OR:   alu_out = i_rs1_data | alu_b;
            rv32ie_pkg::F3_AND:  alu_out = i_rs1_data & alu_b;
            default:             alu_out = '0;
        endcase
    end

    // load lane select
    always_comb begin
        case (ea[1:0])
            2'd0:    ld_byte = i_load_data[7:0];
            2'd1:    ld_byte = i_load_data[15:8];
            2'd2:    ld_byte = i_load_data[23:16];
            default: ld_byte = i_load_data[31:24];
        endcase
        ld_half = ea[1] ? i_load_data[31:16] : i_load_data[15:0];
    end

    always_comb begin
        br_valid = 1'b1;
        case (funct3)
            rv32ie_pkg::F3_BEQ:  taken = eq;
            rv32ie_pkg::F3_BNE:  taken = !eq;
            rv32ie_pkg::F3_BLT:  taken = lt_s;
            rv32ie_pkg::F3_BGE:  taken = !lt_s;
            rv32ie_pkg::F3_BLTU: taken = lt_u;
            rv32ie_pkg::F3_BGEU: taken = !lt_u;
            default: begin
                taken    = 1'b0;
                br_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_res         = '0;
        o_res.next_pc = pc_plus4;
        wr            = 1'b0;
        val           = '0;
        case (opcode)
            rv32ie_pkg::OPC_OP_IMM: begin
                if ((funct3 == rv32ie_pkg::F3_SLL || funct3 == rv32ie_pkg::F3_SR)
                    && !(funct7 == rv32ie_pkg::F7_BASE)
                    && !(funct3 == rv32ie_pkg::F3_SR && funct7 == rv32ie_pkg::F7_ALT)) begin
                    o_res.illegal = 1'b1;
                end else begin
                    wr  = 1'b1;
                    val = alu_out;
                end
            end
            rv32ie_pkg::OPC_OP: begin
                if (funct7 == rv32ie_pkg::F7_BASE
                    || (funct7 == rv32ie_pkg::F7_ALT
                        && (funct3 == rv32ie_pkg::F3_ADD || funct3 == rv32ie_pkg::F3_SR))) begin
                    wr  = 1'b1;
                    val = alu_out;
                end else begin
                    o_res.illegal = 1'b1;
                end
            end
            rv32ie_pkg::OPC_LUI: begin
                wr  = 1'b1;
                val = imm_u;
            end
            rv32ie_pkg::OPC_AUIPC: begin
                wr  = 1'b1;
                val = pc_imm;
            end
            rv32ie_pkg::OPC_JAL: begin
                wr            = 1'b1;
                val           = pc_plus4;
                o_res.next_pc = pc_imm & rv32ie_pkg::WORD_ALIGN;
            end
            rv32ie_pkg::OPC_JALR: begin
                if (funct3 == rv32ie_pkg::F3_JALR) begin
                    wr            = 1'b1;
                    val           = pc_plus4;
                    o_res.next_pc = ea & rv32ie_pkg::WORD_ALIGN;
                end else begin
                    o_res.illegal = 1'b1;
                end
            end
            rv32ie_pkg::OPC_BRANCH: begin
                if (!br_valid) begin
                    o_res.illegal = 1'b1;
                end else if (taken) begin
                    o_res.next_pc = pc_imm & rv32ie_pkg::WORD_ALIGN;
                end
            end
            rv32ie_pkg::OPC_LOAD: begin
                wr             = 1'b1;
                o_res.mem_read = 1'b1;
                o_res.mem_addr = ea;
                case (funct3)
                    rv32ie_pkg::F3_LB: begin
                        val               = {{24{ld_byte[7]}}, ld_byte};
                        o_res.access_size = rv32ie_pkg::SIZE_BYTE;
                    end
                    rv32ie_pkg::F3_LH: begin
                        val               = {{16{ld_half[15]}}, ld_half};
                        o_res.access_size = rv32ie_pkg::SIZE_HALF;
                    end
                    rv32ie_pkg::F3_LW: begin
                        val               = i_load_data;
                        o_res.access_size = rv32ie_pkg::SIZE_WORD;
                    end
                    rv32ie_pkg::F3_LBU: begin
                        val               = {24'd0, ld_byte};
                        o_res.access_size = rv32ie_pkg::SIZE_BYTE;
                    end
                    rv32ie_pkg::F3_LHU: begin
                        val               = {16'd0, ld_half};
                        o_res.access_size = rv32ie_pkg::SIZE_HALF;
                    end
                    default: begin
                        wr             = 1'b0;
                        o_res.mem_read = 1'b0;
                        o_res.mem_addr = '0;
                        o_res.illegal  = 1'b1;
                    end
                endcase
            end
            rv32ie_pkg::OPC_STORE: begin
                o_res.mem_write   = 1'b1;
                o_res.mem_addr    = ea;
                o_res.access_size = funct3[1:0];
                case (funct3)
                    rv32ie_pkg::F3_SB: o_res.store_data = {24'd0, i_rs2_data[7:0]};
                    rv32ie_pkg::F3_SH: o_res.store_data = {16'd0, i_rs2_data[15:0]};
                    rv32ie_pkg::F3_SW: o_res.store_data = i_rs2_data;
                    default: begin
                        o_res.mem_write   = 1'b0;
                        o_res.mem_addr    = '0;
                        o_res.access_size = rv32ie_pkg::SIZE_BYTE;
                        o_res.illegal     = 1'b1;
                    end
                endcase
            end
            rv32ie_pkg::OPC_SYSTEM: begin
                if (i_instr == rv32ie_pkg::EBREAK_WORD) begin
                    o_res.halt = 1'b1;
                end else begin
                    o_res.illegal = 1'b1;
                end
            end
            default: begin
                o_res.illegal = 1'b1;
            end
        endcase

        // x0 is never written; report nothing for it
        if (wr && (rd != 5'd0)) begin
            o_res.dest_reg   = rd;
            o_res.dest_value = val;
        end
    end

endmodule

[design/rv32i_instruction_executor.sv]
// RV32I executor top level: stream ports, input stage, result register.
// Depends on rv32ie_pkg, rv32ie_regfile, rv32ie_exec and the assertion header.
//
// Each slave transaction carries one instruction word (tdata[31:0]) and the
// aligned memory word for a load in it (tdata[63:32]). Each master
// transaction carries the outcome: next pc, register write, memory access
// and the halt / illegal flags.
// An accepted instruction is held in the input stage, then executed and
// registered in the result register, which offers its result. Throughput:
// one instruction per cycle while the master side does not stall.
// The register file read is started at acceptance; the write of the
// instruction ahead is forwarded, so back-to-back dependent instructions
// need no stall.
// Reset clears the pc to zero and marks every register as zero; tready is
// low while reset is asserted. When the master side stalls, the result
// register holds and one further instruction waits in the input stage;
// tready falls only when both are occupied and tready on the master side
// is low.
`include "rv32i_instruction_executor_assert.svh"

module rv32i_instruction_executor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: instr[31:0], load_data[63:32]
    input  logic [rv32ie_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: next_pc[31:0], dest_reg[36:32], dest_value[68:37],
    //        mem_addr[100:69], store_data[132:101], access_size[134:133], zero[135]
    output logic [rv32ie_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // tuser: mem_read[0], mem_write[1], halt[2], illegal[3]
    output logic [rv32ie_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);

    logic                        r_in_valid;
    logic [rv32ie_pkg::XLEN-1:0] r_instr;
    logic [rv32ie_pkg::XLEN-1:0] r_load_data;
    logic [rv32ie_pkg::XLEN-1:0] r_pc;
    logic                        r_out_valid;
    rv32ie_pkg::t_exec_res       r_out;

    logic                        s_accept;
    logic                        fire;
    logic [rv32ie_pkg::XLEN-1:0] rs1_data;
    logic [rv32ie_pkg::XLEN-1:0] rs2_data;
    rv32ie_pkg::t_exec_res       exec_res;
    rv32ie_pkg::t_rf_wr          rf_wr;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_in_valid || fire);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign rf_wr.en   = fire && (exec_res.dest_reg != '0);
    assign rf_wr.addr = exec_res.dest_reg;
    assign rf_wr.data = exec_res.dest_value;

    rv32ie_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (rf_wr),
        .i_rd_en   (s_accept),
        .i_ra_addr (s_axis_tdata[19:15]),
        .i_rb_addr (s_axis_tdata[24:20]),
        .o_ra_data (rs1_data),
        .o_rb_data (rs2_data)
    );

    rv32ie_exec u_exec (
        .i_instr     (r_instr),
        .i_load_data (r_load_data),
        .i_pc        (r_pc),
        .i_rs1_data  (rs1_data),
        .i_rs2_data  (rs2_data),
        .o_res       (exec_res)
    );

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_instr     <= s_axis_tdata[31:0];
            r_load_data <= s_axis_tdata[63:32];
        end
        if (fire) begin
            r_out <= exec_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_pc        <= exec_res.next_pc;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.access_size, r_out.store_data, r_out.mem_addr,
                            r_out.dest_value, r_out.dest_reg, r_out.next_pc};
    assign m_axis_tuser  = {r_out.illegal, r_out.halt, r_out.mem_write, r_out.mem_read};

    `RV32IE_ASSERT_IMP(a_no_x0_write, i_clk, i_rst_n, rf_wr.en, rf_wr.addr != '0, "write to x0")
    `RV32IE_ASSERT_NXT(a_fire_fills_out, i_clk, i_rst_n, fire, r_out_valid && !r_in_valid || r_out_valid && $past(s_accept), "result register not loaded")
    `RV32IE_ASSERT_ALW(a_pc_aligned, i_clk, i_rst_n, r_pc[1:0] == 2'b00, "pc not word aligned")
    `RV32IE_ASSERT_IMP(a_illegal_quiet, i_clk, i_rst_n, r_out_valid && r_out.illegal, r_out.dest_reg == '0 && !r_out.mem_read && !r_out.mem_write && !r_out.halt, "illegal instruction has side effects")

endmodule
